// ===== sv/correlated_gaussian_pair_assert.svh =====
// assertion macros for the correlated gaussian pair checker
`ifndef CORRELATED_GAUSSIAN_PAIR_ASSERT_SVH
`define CORRELATED_GAUSSIAN_PAIR_ASSERT_SVH

// same-cycle implication, off during reset
`define CGP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("correlated_gaussian_pair check failed");

// next-cycle implication, off during reset
`define CGP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("correlated_gaussian_pair check failed");

// next-cycle implication that also watches reset itself
`define CGP_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("correlated_gaussian_pair reset check failed");

`endif

// ===== sv/cgp_pkg.sv =====
// shared constants and stage payload types for the correlated gaussian pair
package cgp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int Q_W           = 32;
  localparam int DIV_STEPS     = 31;
  localparam int SQRT_STEPS    = 31;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // carried alongside the divider
  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic        [30:0] sx;
    logic        [30:0] sy;
    logic signed [31:0] z1;
    logic signed [31:0] z2;
  } div_sb_t;

  // carried alongside the square root
  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic        [30:0] sx;
    logic signed [31:0] z1;
    logic signed [31:0] z2;
    logic signed [31:0] l10;
    logic               npd;
  } sqrt_sb_t;

  localparam int DIV_SB_W  = $bits(div_sb_t);
  localparam int SQRT_SB_W = $bits(sqrt_sb_t);

endpackage

// ===== sv/cgp_div.sv =====
// pipelined restoring divider: l10 = (covariance << frac) / sigma_first, one bit a stage
module cgp_div import cgp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SB_W      = DIV_SB_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [31:0]  cv,
  input  logic        [30:0]  sx,
  input  logic [SB_W-1:0]     sb_in,
  output logic                out_vld,
  output logic signed [31:0]  l10,
  output logic        [30:0]  l10_mag,
  output logic                ovf,
  output logic [SB_W-1:0]     sb_out
);

  localparam int NUM_W = Q_W + FRAC_BITS;

  logic [31:0]      cv_mag;
  logic [NUM_W-1:0] num;
  logic [FRAC_BITS:0] num_hi;

  logic            vld_r  [0:DIV_STEPS];
  logic [30:0]     rem_r  [0:DIV_STEPS];
  logic [30:0]     low_r  [0:DIV_STEPS];
  logic [30:0]     quo_r  [0:DIV_STEPS];
  logic [30:0]     sx_r   [0:DIV_STEPS];
  logic            neg_r  [0:DIV_STEPS];
  logic            zero_r [0:DIV_STEPS];
  logic            ovf_r  [0:DIV_STEPS];
  logic [SB_W-1:0] sb_r   [0:DIV_STEPS];

  logic [31:0] q_ext;

  assign cv_mag = cv[31] ? (~cv + 32'd1) : cv;
  assign num    = {cv_mag, {FRAC_BITS{1'b0}}};
  assign num_hi = num[NUM_W-1:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= 31'(num_hi);
      low_r[0]  <= num[DIV_STEPS-1:0];
      quo_r[0]  <= '0;
      sx_r[0]   <= sx;
      neg_r[0]  <= cv[31];
      zero_r[0] <= (sx == 31'd0);
      // quotient would need 32 or more bits
      ovf_r[0]  <= (32'(num_hi) >= 32'(sx));
      sb_r[0]   <= sb_in;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    assign trial = {rem_r[k], low_r[k][30]};
    assign diff  = trial - {1'b0, sx_r[k]};
    assign ge    = (trial >= {1'b0, sx_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[30:0] : trial[30:0];
        low_r[k+1]  <= {low_r[k][29:0], 1'b0};
        quo_r[k+1]  <= {quo_r[k][29:0], ge};
        sx_r[k+1]   <= sx_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        sb_r[k+1]   <= sb_r[k];
      end
    end
  end

  assign q_ext = {1'b0, quo_r[DIV_STEPS]};

  always_comb begin
    if (zero_r[DIV_STEPS]) begin
      l10 = '0;
    end else if (ovf_r[DIV_STEPS]) begin
      l10 = neg_r[DIV_STEPS] ? Q_MIN : Q_MAX;
    end else if (neg_r[DIV_STEPS]) begin
      l10 = signed'(~q_ext + 32'd1);
    end else begin
      l10 = signed'(q_ext);
    end
  end

  assign out_vld = vld_r[DIV_STEPS];
  assign l10_mag = zero_r[DIV_STEPS] ? 31'd0 : quo_r[DIV_STEPS];
  assign ovf     = ovf_r[DIV_STEPS] & ~zero_r[DIV_STEPS];
  assign sb_out  = sb_r[DIV_STEPS];

endmodule

// ===== sv/cgp_sqrt.sv =====
// pipelined digit-by-digit integer square root of a 62-bit radicand, one root bit a stage
module cgp_sqrt import cgp_pkg::*; #(
  parameter int SB_W = SQRT_SB_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [61:0]     rad,
  input  logic [SB_W-1:0] sb_in,
  output logic            out_vld,
  output logic [30:0]     root,
  output logic [SB_W-1:0] sb_out
);

  logic            vld_r [0:SQRT_STEPS];
  logic [31:0]     rem_r [0:SQRT_STEPS];
  logic [30:0]     q_r   [0:SQRT_STEPS];
  logic [61:0]     rad_r [0:SQRT_STEPS];
  logic [SB_W-1:0] sb_r  [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      q_r[0]   <= '0;
      rad_r[0] <= rad;
      sb_r[0]  <= sb_in;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [33:0] trial;
    logic [33:0] test;
    logic [33:0] diff;
    logic        ge;

    // bring down the next pair of radicand bits
    assign trial = {rem_r[k], rad_r[k][61:60]};
    assign test  = {1'b0, q_r[k], 2'b01};
    assign diff  = trial - test;
    assign ge    = (trial >= test);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[31:0] : trial[31:0];
        q_r[k+1]   <= {q_r[k][29:0], ge};
        rad_r[k+1] <= {rad_r[k][59:0], 2'b00};
        sb_r[k+1]  <= sb_r[k];
      end
    end
  end

  assign out_vld = vld_r[SQRT_STEPS];
  assign root    = q_r[SQRT_STEPS];
  assign sb_out  = sb_r[SQRT_STEPS];

endmodule

// ===== sv/correlated_gaussian_pair.sv =====
// top level: bivariate gaussian pair from a 2x2 cholesky factor, fully pipelined
//
// Requests enter on the in_ channel (valid/ready) with two means, two deviations,
// a covariance and two standard-normal samples; results leave on the out_ channel
// (valid/ready) with the two correlated values and the two flags.
// From acceptance to out_valid a request passes 32 divider stages, a square
// stage, 32 square-root stages, then product, rounding and saturation stages.
// Throughput is one request per cycle when not stalled; each gives exactly one result.
// The divider bit loop and the square-root bit loop set the depth.
// The whole pipeline moves together: when out_valid is high and out_ready low,
// every stage holds and in_ready drops in the same cycle, so nothing is lost.
// Bubbles in the pipeline are not squeezed out during a stall.
// A synchronous reset (rst_n low) clears all valid bits; data registers keep
// whatever they hold and are ignored until new requests arrive.
// FRAC_BITS sets the binary point of every Q format (8 to 24).
module correlated_gaussian_pair import cgp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_mean_first,
  input  logic signed [31:0] in_mean_second,
  input  logic        [30:0] in_sigma_first,
  input  logic        [30:0] in_sigma_second,
  input  logic signed [31:0] in_covariance,
  input  logic signed [31:0] in_normal_sample_a,
  input  logic signed [31:0] in_normal_sample_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value_first,
  output logic signed [31:0] out_value_second,
  output logic               out_not_positive_definite,
  output logic               out_saturated
);

  localparam logic signed [65:0] HALF = signed'(66'(1) << (FRAC_BITS - 1));
  localparam logic signed [66:0] VMAX = 67'(Q_MAX);
  localparam logic signed [66:0] VMIN = 67'(Q_MIN);

  logic en;

  div_sb_t            dsb_in, dsb_out;
  logic               div_vld;
  logic signed [31:0] div_l10;
  logic        [30:0] div_mag;
  logic               div_ovf;

  // square stage
  logic               a_vld_r;
  logic        [61:0] a_s2_r;
  logic        [61:0] a_a2_r;
  logic signed [31:0] a_l10_r;
  logic               a_ovf_r;
  div_sb_t            a_sb_r;

  logic               b_npd;
  logic        [61:0] b_rad;
  sqrt_sb_t           ssb_in, ssb_out;
  logic               sq_vld;
  logic        [30:0] sq_root;

  // product stage
  logic               c_vld_r;
  logic signed [63:0] c_p1_r, c_p2_r, c_p3_r;
  logic signed [31:0] c_mx_r, c_my_r;
  logic               c_npd_r;

  // rounding stage
  logic               d_vld_r;
  logic signed [65:0] d_r1_r, d_r2_r;
  logic signed [31:0] d_mx_r, d_my_r;
  logic               d_npd_r;
  logic signed [65:0] d_sum1, d_sum2;

  // output stage
  logic signed [66:0] e_v1, e_v2;
  logic signed [31:0] e_o1, e_o2;
  logic               e_sat1, e_sat2;
  logic               out_valid_r;
  logic signed [31:0] out_value_first_r, out_value_second_r;
  logic               out_npd_r, out_sat_r;

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  assign dsb_in.mx = in_mean_first;
  assign dsb_in.my = in_mean_second;
  assign dsb_in.sx = in_sigma_first;
  assign dsb_in.sy = in_sigma_second;
  assign dsb_in.z1 = in_normal_sample_a;
  assign dsb_in.z2 = in_normal_sample_b;

  cgp_div #(
    .FRAC_BITS (FRAC_BITS),
    .SB_W      (DIV_SB_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .cv      (in_covariance),
    .sx      (in_sigma_first),
    .sb_in   (dsb_in),
    .out_vld (div_vld),
    .l10     (div_l10),
    .l10_mag (div_mag),
    .ovf     (div_ovf),
    .sb_out  (dsb_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s2_r  <= 62'(dsb_out.sy) * 62'(dsb_out.sy);
      a_a2_r  <= 62'(div_mag) * 62'(div_mag);
      a_l10_r <= div_l10;
      a_ovf_r <= div_ovf;
      a_sb_r  <= dsb_out;
    end
  end

  // a negative radicand or a divider overflow forces l11 to zero
  assign b_npd = a_ovf_r | (a_a2_r > a_s2_r);
  assign b_rad = b_npd ? 62'd0 : (a_s2_r - a_a2_r);

  assign ssb_in.mx  = a_sb_r.mx;
  assign ssb_in.my  = a_sb_r.my;
  assign ssb_in.sx  = a_sb_r.sx;
  assign ssb_in.z1  = a_sb_r.z1;
  assign ssb_in.z2  = a_sb_r.z2;
  assign ssb_in.l10 = a_l10_r;
  assign ssb_in.npd = b_npd;

  cgp_sqrt #(
    .SB_W (SQRT_SB_W)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (a_vld_r),
    .rad     (b_rad),
    .sb_in   (ssb_in),
    .out_vld (sq_vld),
    .root    (sq_root),
    .sb_out  (ssb_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= sq_vld;
      d_vld_r <= c_vld_r;
      out_valid_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_p1_r  <= 64'(signed'({1'b0, ssb_out.sx})) * 64'(ssb_out.z1);
      c_p2_r  <= 64'(ssb_out.l10) * 64'(ssb_out.z1);
      c_p3_r  <= 64'(signed'({1'b0, sq_root})) * 64'(ssb_out.z2);
      c_mx_r  <= ssb_out.mx;
      c_my_r  <= ssb_out.my;
      c_npd_r <= ssb_out.npd;
    end
  end

  // round half up from Q.2F to Q.F
  assign d_sum1 = 66'(c_p1_r) + HALF;
  assign d_sum2 = 66'(c_p2_r) + 66'(c_p3_r) + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      d_r1_r  <= d_sum1 >>> FRAC_BITS;
      d_r2_r  <= d_sum2 >>> FRAC_BITS;
      d_mx_r  <= c_mx_r;
      d_my_r  <= c_my_r;
      d_npd_r <= c_npd_r;
    end
  end

  assign e_v1 = 67'(d_r1_r) + 67'(d_mx_r);
  assign e_v2 = 67'(d_r2_r) + 67'(d_my_r);

  always_comb begin
    e_sat1 = 1'b1;
    if (e_v1 > VMAX) begin
      e_o1 = Q_MAX;
    end else if (e_v1 < VMIN) begin
      e_o1 = Q_MIN;
    end else begin
      e_o1   = e_v1[31:0];
      e_sat1 = 1'b0;
    end
    e_sat2 = 1'b1;
    if (e_v2 > VMAX) begin
      e_o2 = Q_MAX;
    end else if (e_v2 < VMIN) begin
      e_o2 = Q_MIN;
    end else begin
      e_o2   = e_v2[31:0];
      e_sat2 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_first_r  <= e_o1;
      out_value_second_r <= e_o2;
      out_npd_r          <= d_npd_r;
      out_sat_r          <= e_sat1 | e_sat2;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_value_first           = out_value_first_r;
  assign out_value_second          = out_value_second_r;
  assign out_not_positive_definite = out_npd_r;
  assign out_saturated             = out_sat_r;

endmodule

// ===== sv/cgp_checker.sv =====
// port-level checks for the correlated gaussian pair, bound to the top level
`include "correlated_gaussian_pair_assert.svh"

module cgp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_value_first,
  input logic signed [31:0] out_value_second,
  input logic               out_not_positive_definite,
  input logic               out_saturated
);

  logic [65:0] out_word;

  assign out_word = {out_value_first, out_value_second, out_not_positive_definite,
                     out_saturated};

  // reset empties the pipeline
  `CGP_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

  // an empty output register never blocks the input
  `CGP_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

  // a result taken frees the pipeline in the same cycle
  `CGP_ASSERT_IMP(a_ready_on_take, out_valid && out_ready, in_ready)

  // a stalled result holds
  `CGP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind correlated_gaussian_pair cgp_checker u_cgp_checker (.*);

// ===== sim/tb_correlated_gaussian_pair.sv =====
// self-checking testbench for the correlated gaussian pair block
module tb_correlated_gaussian_pair;
  import cgp_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;
  localparam int N_RANDOM = 900;

  typedef struct {
    logic signed [31:0] mx, my;
    logic        [30:0] sx, sy;
    logic signed [31:0] cv, z1, z2;
  } pair_request_t;

  typedef struct {
    logic signed [31:0] vf, vs;
    logic               npd, sat;
  } pair_result_t;

  typedef struct {
    pair_request_t req;
    bit            typed;
    pair_result_t  want;
  } directed_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_mean_first, in_mean_second, in_covariance;
  logic        [30:0] in_sigma_first, in_sigma_second;
  logic signed [31:0] in_normal_sample_a, in_normal_sample_b;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_value_first, out_value_second;
  logic               out_not_positive_definite, out_saturated;

  pair_result_t pending_pairs[$];
  int           mismatches;
  bit           calm;

  correlated_gaussian_pair u_top (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_mean_first             (in_mean_first),
    .in_mean_second            (in_mean_second),
    .in_sigma_first            (in_sigma_first),
    .in_sigma_second           (in_sigma_second),
    .in_covariance             (in_covariance),
    .in_normal_sample_a        (in_normal_sample_a),
    .in_normal_sample_b        (in_normal_sample_b),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_value_first           (out_value_first),
    .out_value_second          (out_value_second),
    .out_not_positive_definite (out_not_positive_definite),
    .out_saturated             (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  // floor(v / 2^frac + 1/2)
  function automatic longint round_half_up(longint v);
    return (v >>> FRAC) + longint'(v[FRAC-1]);
  endfunction

  function automatic pair_result_t cholesky_pair(pair_request_t r);
    longint l10w, l10, l11, mag, s2, a2, vx, vy;
    pair_result_t res;
    l10w = 0;
    l11 = 0;
    res.npd = 1'b0;
    if (r.sx != 0) l10w = (longint'(r.cv) <<< FRAC) / longint'(r.sx);
    if (l10w > QHI || l10w < -QHI) begin
      res.npd = 1'b1;
    end else begin
      mag = (l10w < 0) ? -l10w : l10w;
      s2 = longint'(r.sy) * longint'(r.sy);
      a2 = mag * mag;
      if (a2 > s2) res.npd = 1'b1;
      else l11 = longint'(int_sqrt(s2 - a2));
    end
    l10 = clamp_q(l10w);
    vx = longint'(r.mx) + round_half_up(longint'(r.sx) * longint'(r.z1));
    vy = longint'(r.my) + round_half_up(l10 * longint'(r.z1) + l11 * longint'(r.z2));
    res.sat = (clamp_q(vx) != vx) || (clamp_q(vy) != vy);
    res.vf = 32'(clamp_q(vx));
    res.vs = 32'(clamp_q(vy));
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      2: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic logic [30:0] pick_sigma();
    case ($urandom_range(4))
      0: return 31'($urandom);
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(0, 2));
      default: return 31'($urandom_range(1, 1 << 19));
    endcase
  endfunction

  function automatic pair_request_t random_request();
    pair_request_t r;
    longint prod;
    r.mx = pick_word();
    r.my = pick_word();
    r.sx = pick_sigma();
    r.sy = pick_sigma();
    r.z1 = pick_word();
    r.z2 = pick_word();
    r.cv = pick_word();
    // mostly a valid correlation so the square root path sees real work
    if ($urandom_range(99) < 60) begin
      prod = (longint'(r.sx) * longint'(r.sy)) >>> FRAC;
      prod = (prod * ($signed($urandom_range(0, 16)) - 8)) / 8;
      r.cv = 32'(clamp_q(prod));
    end
    return r;
  endfunction

  task automatic send_request(pair_request_t r);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_mean_first      <= r.mx;
    in_mean_second     <= r.my;
    in_sigma_first     <= r.sx;
    in_sigma_second    <= r.sy;
    in_covariance      <= r.cv;
    in_normal_sample_a <= r.z1;
    in_normal_sample_b <= r.z2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  directed_row_t plan[14] = '{
    '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0}},
    '{'{32'sh7fffffff, 32'sh80000000, 1, 0, 0, 0, 0}, 1,
      '{32'sh7fffffff, 32'sh80000000, 0, 0}},
    '{'{32'sh7fffffff, 0, 65536, 0, 0, 65536, 0}, 1, '{32'sh7fffffff, 0, 0, 1}},
    '{'{32'sh80000000, 0, 65536, 0, 0, -65536, 0}, 1, '{32'sh80000000, 0, 0, 1}},
    '{'{3, 4, 65536, 65536, 131072, 0, 0}, 1, '{3, 4, 1, 0}},
    '{'{7, 0, 0, 65536, 12345, 99, 65536}, 1, '{7, 65536, 0, 0}},
    '{'{0, 0, 65536, 65536, 65536, 65536, 777}, 1, '{65536, 65536, 0, 0}},
    '{'{0, 0, 1, 0, 0, 32768, 0}, 1, '{1, 0, 0, 0}},
    '{'{0, 0, 1, 0, 0, -32768, 0}, 1, '{0, 0, 0, 0}},
    '{'{0, 0, 1, 65536, 32'sh7fffffff, 65536, 65536}, 0, '{0, 0, 0, 0}},
    '{'{0, 0, 1, 65536, 32'sh80000000, 65536, 65536}, 0, '{0, 0, 0, 0}},
    '{'{0, 0, 31'h7fffffff, 31'h7fffffff, 0, 32'sh7fffffff, 32'sh80000000}, 0,
      '{0, 0, 0, 0}},
    '{'{-1, -1, 31'h7fffffff, 31'h7fffffff, -1, -1, -1}, 0, '{0, 0, 0, 0}},
    '{'{100000, -100000, 98304, 131072, -65536, -70000, 50000}, 0, '{0, 0, 0, 0}}
  };

  // stimulus
  initial begin
    pair_request_t r;
    mismatches = 0;
    calm <= 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mean_first <= '0;
    in_mean_second <= '0;
    in_sigma_first <= '0;
    in_sigma_second <= '0;
    in_covariance <= '0;
    in_normal_sample_a <= '0;
    in_normal_sample_b <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[i]) begin
      send_request(plan[i].req);
      pending_pairs.push_back(plan[i].typed ? plan[i].want : cholesky_pair(plan[i].req));
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) calm <= 1'b1;
      if (n == 450) calm <= 1'b0;
      if (n == 600) begin
        // let the pipeline drain completely before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pairs.size() != 0) @(posedge clk);
      end
      r = random_request();
      send_request(r);
      pending_pairs.push_back(cholesky_pair(r));
    end
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (pending_pairs.size() != 0) report_mismatch("leftover results", pending_pairs.size(), 0);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    pair_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected result", out_value_first, 0);
      end else begin
        want = pending_pairs.pop_front();
        if (out_value_first !== want.vf)
          report_mismatch("value_first", out_value_first, want.vf);
        if (out_value_second !== want.vs)
          report_mismatch("value_second", out_value_second, want.vs);
        if (out_not_positive_definite !== want.npd)
          report_mismatch("not_positive_definite", out_not_positive_definite, want.npd);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", out_saturated, want.sat);
      end
    end
  end

endmodule
